/* src/lsse_pkg.sv */
// shared types, pattern codes and steering constants for the line sensor steering block
package lsse_pkg;

    // sample width in use; fields arrive 12 bits wide
    localparam int SAMPLE_BITS = 12;
    localparam int FIELD_BITS  = 12;
    localparam int CMP_BITS    = (SAMPLE_BITS < FIELD_BITS) ? SAMPLE_BITS : FIELD_BITS;

    localparam logic [FIELD_BITS-1:0] THRESHOLD_RESET = 12'd2048;

    typedef logic [3:0]         pattern_t;
    typedef logic signed [11:0] steer_t;
    typedef logic signed [10:0] stored_err_t;

    // black patterns, bit 0 outer left .. bit 3 outer right
    localparam pattern_t PAT_WHITE     = 4'h0;
    localparam pattern_t PAT_OL        = 4'h1;
    localparam pattern_t PAT_IL        = 4'h2;
    localparam pattern_t PAT_OL_IL     = 4'h3;
    localparam pattern_t PAT_CROSS_A   = 4'h5;
    localparam pattern_t PAT_STRAIGHT  = 4'h6;
    localparam pattern_t PAT_LEFT3     = 4'h7;
    localparam pattern_t PAT_OR        = 4'h8;
    localparam pattern_t PAT_CROSS_B   = 4'h9;
    localparam pattern_t PAT_CROSS_C   = 4'hA;
    localparam pattern_t PAT_GAP_IR    = 4'hB;
    localparam pattern_t PAT_IR        = 4'h4;
    localparam pattern_t PAT_IR_OR     = 4'hC;
    localparam pattern_t PAT_GAP_IL    = 4'hD;
    localparam pattern_t PAT_RIGHT3    = 4'hE;
    localparam pattern_t PAT_ALL_BLACK = 4'hF;

    typedef enum logic [1:0] {
        TREND_STRAIGHT = 2'd0,
        TREND_LEFT     = 2'd1,
        TREND_RIGHT    = 2'd2
    } trend_t;

    // errors in hundredths
    localparam steer_t ERR_NEAR  = 12'sd180;
    localparam steer_t ERR_MID   = 12'sd280;
    localparam steer_t ERR_WIDE  = 12'sd350;
    localparam steer_t ERR_EDGE  = 12'sd420;
    localparam steer_t ERR_CROSS = 12'sd190;
    localparam steer_t ERR_LIMIT = 12'sd1200;

    localparam logic [10:0] STRENGTH_BASE = 11'd400;
    localparam logic [10:0] STRENGTH_STEP = 11'd25;
    localparam logic [10:0] STRENGTH_MAX  = 11'd1200;
    localparam logic [5:0]  LOST_MAX      = 6'd63;
    localparam logic [1:0]  GLITCH_MAX    = 2'd3;
    localparam logic [1:0]  GLITCH_PASS   = 2'd2;

    // x/10 as (x * 6554) >> 16, exact for x below 16384
    localparam logic [26:0] RECIP_TENTH = 27'd6554;
    localparam int          RECIP_SHIFT = 16;

    typedef struct packed {
        logic [FIELD_BITS-1:0] sample_outer_left;
        logic [FIELD_BITS-1:0] sample_inner_left;
        logic [FIELD_BITS-1:0] sample_inner_right;
        logic [FIELD_BITS-1:0] sample_outer_right;
    } sample_t;

    typedef struct packed {
        steer_t   steer_error;
        pattern_t filtered_pattern;
    } result_t;

endpackage

/* src/lsse_filter.sv */
// pattern validation, trend and lost-line state, and steering error selection
module lsse_filter
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  lsse_pkg::pattern_t  raw,
    output lsse_pkg::result_t   step_result
);

    lsse_pkg::pattern_t    last_valid_pattern_reg, last_valid_pattern_next;
    logic [1:0]            glitch_count_reg, glitch_count_next;
    lsse_pkg::stored_err_t last_error_reg, last_error_next;
    logic [5:0]            lost_count_reg, lost_count_next;
    lsse_pkg::trend_t      curve_trend_reg, curve_trend_next;

    lsse_pkg::pattern_t diff;
    logic [2:0]         diff_count;
    logic               jump_big;
    logic [1:0]         glitch_inc;
    logic               hold_prev;
    logic               is_cross;
    lsse_pkg::pattern_t pat;

    logic [10:0]        mag;
    logic [13:0]        mag_x7;
    logic [26:0]        prod;
    logic [9:0]         quot;
    lsse_pkg::steer_t   scaled;

    logic [10:0]        strength_raw;
    logic [10:0]        strength;
    logic               steer_left;
    lsse_pkg::steer_t   err;

    // validation
    always_comb
    begin
        diff       = raw ^ last_valid_pattern_reg;
        diff_count = {2'b00, diff[0]} + {2'b00, diff[1]} + {2'b00, diff[2]} + {2'b00, diff[3]};
        jump_big   = (diff_count >= 3'd3);
        glitch_inc = (glitch_count_reg == lsse_pkg::GLITCH_MAX) ? glitch_count_reg
                                                                : glitch_count_reg + 2'd1;
        is_cross   = (raw == lsse_pkg::PAT_CROSS_A) || (raw == lsse_pkg::PAT_CROSS_B)
                  || (raw == lsse_pkg::PAT_CROSS_C);
        hold_prev  = 1'b0;
        if (raw == lsse_pkg::PAT_STRAIGHT)
        begin
            glitch_count_next = 2'd0;
        end
        else if (jump_big)
        begin
            glitch_count_next = glitch_inc;
            hold_prev         = (glitch_inc < lsse_pkg::GLITCH_PASS);
        end
        else
        begin
            glitch_count_next = 2'd0;
        end
        if (raw != lsse_pkg::PAT_STRAIGHT && (hold_prev || is_cross))
            pat = last_valid_pattern_reg;
        else
            pat = raw;
        last_valid_pattern_next = pat;
    end

    // 7/10 of last error, rounded half away from zero
    always_comb
    begin
        mag    = 11'(last_error_reg[10] ? -last_error_reg : last_error_reg);
        mag_x7 = 14'({3'b000, mag} * 14'd7) + 14'd5;
        prod   = 27'(mag_x7) * lsse_pkg::RECIP_TENTH;
        quot   = prod[lsse_pkg::RECIP_SHIFT +: 10];
        scaled = last_error_reg[10] ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
    end

    // trend, lost count and error
    always_comb
    begin
        curve_trend_next = curve_trend_reg;
        lost_count_next  = lost_count_reg;
        last_error_next  = last_error_reg;
        err              = '0;

        strength_raw = lsse_pkg::STRENGTH_BASE
                     + 11'({5'b00000, lost_count_next} * lsse_pkg::STRENGTH_STEP);
        strength     = '0;
        steer_left   = (curve_trend_reg == lsse_pkg::TREND_LEFT) || (last_error_reg > 11'sd0);

        unique case (pat)
            lsse_pkg::PAT_IR, lsse_pkg::PAT_IR_OR, lsse_pkg::PAT_OR, lsse_pkg::PAT_RIGHT3:
                curve_trend_next = lsse_pkg::TREND_LEFT;
            lsse_pkg::PAT_IL, lsse_pkg::PAT_OL_IL, lsse_pkg::PAT_OL, lsse_pkg::PAT_LEFT3:
                curve_trend_next = lsse_pkg::TREND_RIGHT;
            lsse_pkg::PAT_STRAIGHT:
                curve_trend_next = lsse_pkg::TREND_STRAIGHT;
            default:
                curve_trend_next = curve_trend_reg;
        endcase

        unique case (pat)
            lsse_pkg::PAT_STRAIGHT:
            begin
                err             = '0;
                last_error_next = '0;
                lost_count_next = '0;
            end
            lsse_pkg::PAT_IL:    err = -lsse_pkg::ERR_NEAR;
            lsse_pkg::PAT_IR:    err =  lsse_pkg::ERR_NEAR;
            lsse_pkg::PAT_OL_IL: err = -lsse_pkg::ERR_MID;
            lsse_pkg::PAT_IR_OR: err =  lsse_pkg::ERR_MID;
            lsse_pkg::PAT_LEFT3: err = -lsse_pkg::ERR_WIDE;
            lsse_pkg::PAT_RIGHT3: err = lsse_pkg::ERR_WIDE;
            lsse_pkg::PAT_OL:    err = -lsse_pkg::ERR_EDGE;
            lsse_pkg::PAT_OR:    err =  lsse_pkg::ERR_EDGE;
            lsse_pkg::PAT_ALL_BLACK:
            begin
                lost_count_next = '0;
                if (curve_trend_reg == lsse_pkg::TREND_LEFT)
                    err = lsse_pkg::ERR_CROSS;
                else if (curve_trend_reg == lsse_pkg::TREND_RIGHT)
                    err = -lsse_pkg::ERR_CROSS;
                else
                    err = '0;
            end
            lsse_pkg::PAT_WHITE:
            begin
                if (lost_count_reg != lsse_pkg::LOST_MAX)
                    lost_count_next = lost_count_reg + 6'd1;
                strength_raw = lsse_pkg::STRENGTH_BASE
                             + 11'({5'b00000, lost_count_next} * lsse_pkg::STRENGTH_STEP);
                strength = (strength_raw > lsse_pkg::STRENGTH_MAX) ? lsse_pkg::STRENGTH_MAX
                                                                    : strength_raw;
                err = steer_left ? $signed({1'b0, strength}) : -$signed({1'b0, strength});
            end
            default:
                err = scaled;
        endcase

        // table patterns remember their error
        if (pat != lsse_pkg::PAT_STRAIGHT && pat != lsse_pkg::PAT_ALL_BLACK
            && pat != lsse_pkg::PAT_WHITE && pat != lsse_pkg::PAT_GAP_IR
            && pat != lsse_pkg::PAT_GAP_IL
            && pat != lsse_pkg::PAT_CROSS_A && pat != lsse_pkg::PAT_CROSS_B
            && pat != lsse_pkg::PAT_CROSS_C)
            last_error_next = 11'(err);

        step_result.steer_error      = err;
        step_result.filtered_pattern = pat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_valid_pattern_reg <= lsse_pkg::PAT_STRAIGHT;
            glitch_count_reg       <= '0;
            last_error_reg         <= '0;
            lost_count_reg         <= '0;
            curve_trend_reg        <= lsse_pkg::TREND_STRAIGHT;
        end
        else if (step)
        begin
            last_valid_pattern_reg <= last_valid_pattern_next;
            glitch_count_reg       <= glitch_count_next;
            last_error_reg         <= last_error_next;
            lost_count_reg         <= lost_count_next;
            curve_trend_reg        <= curve_trend_next;
        end
    end

endmodule

/* src/line_sensor_steering_error.sv */
// top level: threshold register, input pattern stage and result register
//
// Takes one beat of four line-sensor samples per clock while sample_ready is high and returns one
// result beat per sample beat: the validated 4-bit black pattern and a signed steering error in
// hundredths. A sample strictly below the threshold register counts as black. The threshold
// compare is registered into a 4-bit pattern stage, and validation, trend tracking and the error
// pick run combinationally from that stage into the result register. Throughput is one beat per
// clock while result_ready holds; the filter state updates once per beat. Each stage moves only
// when the one after it can take the beat: the result register loads only while it is empty or
// being drained, and the pattern stage also fills while it is empty. The threshold may only
// be written while no beat is in flight; cfg_ready is always high.
module line_sensor_steering_error
(
    input  logic                                clk,
    input  logic                                rst_n,

    // sample channel
    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  lsse_pkg::sample_t                   sample,

    // result channel
    output logic                                result_valid,
    input  logic                                result_ready,
    output lsse_pkg::result_t                   result,

    // threshold write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lsse_pkg::FIELD_BITS-1:0]     cfg_threshold
);

    localparam int CB = lsse_pkg::CMP_BITS;

    logic [lsse_pkg::FIELD_BITS-1:0] threshold_reg;

    // pattern stage
    logic               s1_valid_reg, s1_valid_next;
    lsse_pkg::pattern_t raw_reg;
    lsse_pkg::pattern_t raw_next;

    // result stage
    logic               result_valid_reg, result_valid_next;
    lsse_pkg::result_t  result_reg;

    logic               s2_ready;
    logic               s1_advance;
    lsse_pkg::result_t  step_result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            threshold_reg <= lsse_pkg::THRESHOLD_RESET;
        else if (cfg_valid)
            threshold_reg <= cfg_threshold;
    end

    // handshake chain: each stage moves when the one after it can take the beat
    assign s2_ready     = !result_valid_reg || result_ready;
    assign s1_advance   = s1_valid_reg && s2_ready;
    assign sample_ready = !s1_valid_reg || s2_ready;

    always_comb
    begin
        // black when below threshold, low bits only
        raw_next[0] = sample.sample_outer_left[CB-1:0]  < threshold_reg[CB-1:0];
        raw_next[1] = sample.sample_inner_left[CB-1:0]  < threshold_reg[CB-1:0];
        raw_next[2] = sample.sample_inner_right[CB-1:0] < threshold_reg[CB-1:0];
        raw_next[3] = sample.sample_outer_right[CB-1:0] < threshold_reg[CB-1:0];

        s1_valid_next = sample_ready ? sample_valid : s1_valid_reg;
        result_valid_next = s2_ready ? s1_valid_reg : result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
            raw_reg <= raw_next;
        if (s1_advance)
            result_reg <= step_result;
    end

    // filter state steps once per beat leaving the pattern stage
    lsse_filter u_filter
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (s1_advance),
        .raw         (raw_reg),
        .step_result (step_result)
    );

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // cross patterns never leave the filter
    a_no_cross_out: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.filtered_pattern != lsse_pkg::PAT_CROSS_A)
                      && (result.filtered_pattern != lsse_pkg::PAT_CROSS_B)
                      && (result.filtered_pattern != lsse_pkg::PAT_CROSS_C))
        else $error("cross pattern reached the result");

    // centered line gives no error
    a_straight_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.filtered_pattern == lsse_pkg::PAT_STRAIGHT)
        |-> (result.steer_error == '0))
        else $error("straight pattern with nonzero error");

    // error stays within the lost-line limit
    a_error_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.steer_error <= lsse_pkg::ERR_LIMIT)
                      && (result.steer_error >= -lsse_pkg::ERR_LIMIT))
        else $error("steering error out of range");

    // a pattern beat blocked by a full result register is kept
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_ready |=> s1_valid_reg && $stable(raw_reg))
        else $error("pattern stage lost a blocked beat");

endmodule
